FILE: sv/gfmp_pkg.sv
// ----------------------------------------------------------------------------
// gfmp_pkg: shared types, constants and field functions
// Holds the GF(2^128) arithmetic helpers (squaring, reduction, sliced
// multiply step) and the word that travels between the pipeline rounds.
// ----------------------------------------------------------------------------
package gfmp_pkg;

  // Field element width and the multiplier slice handled per pipeline stage.
  localparam int unsigned GfW       = 128;
  localparam int unsigned ChunkW    = 32;
  localparam int unsigned NumSlices = GfW / ChunkW;

  // Low part of the reduction polynomial x^128 + x^7 + x^2 + x + 1.
  localparam logic [7:0]     RedPoly = 8'h87;
  localparam logic [GfW-1:0] GfOne   = 128'h1;

  // Operation codes carried in the kind field.
  localparam logic KindMul = 1'b0;
  localparam logic KindPow = 1'b1;

  // Word passed from one exponent round to the next.
  typedef struct packed {
    logic           valid;
    logic           kind;
    logic           pend;   // multiply still owes its single product with a
    logic [GfW-1:0] a;
    logic [GfW-1:0] acc;
  } gfmp_word_t;

  // Multiply an overflow part by the low part of the reduction polynomial.
  function automatic logic [GfW+6:0] gf_fold(input logic [GfW-1:0] h);
    logic [GfW+6:0] f;
    f = '0;
    for (int k = 0; k < 8; k++) begin
      if (RedPoly[k]) begin
        f = f ^ ({7'b0, h} << k);
      end
    end
    return f;
  endfunction

  // Squaring is linear over GF(2): spread the bits, then reduce twice.
  function automatic logic [GfW-1:0] gf_sqr(input logic [GfW-1:0] x);
    logic [2*GfW-1:0] s;
    logic [GfW+6:0]   f1;
    logic [GfW+6:0]   f2;
    s = '0;
    for (int i = 0; i < GfW; i++) begin
      s[2*i] = x[i];
    end
    f1 = gf_fold(s[2*GfW-1:GfW]);
    f2 = gf_fold(GfW'(f1[GfW+6:GfW]));
    return s[GfW-1:0] ^ f1[GfW-1:0] ^ f2[GfW-1:0];
  endfunction

  // One Horner step: t * x^ChunkW + x * c, reduced. c is a slice of the
  // multiplier, taken from the most significant slice down.
  function automatic logic [GfW-1:0] gf_step(input logic [GfW-1:0]    t,
                                             input logic [GfW-1:0]    x,
                                             input logic [ChunkW-1:0] c);
    logic [GfW+ChunkW-1:0] p;
    logic [GfW+6:0]        f;
    p = {t, {ChunkW{1'b0}}};
    for (int k = 0; k < ChunkW; k++) begin
      if (c[k]) begin
        p = p ^ ({{ChunkW{1'b0}}, x} << k);
      end
    end
    f = gf_fold(GfW'(p[GfW+ChunkW-1:GfW]));
    return p[GfW-1:0] ^ f[GfW-1:0];
  endfunction

endpackage

FILE: sv/gfmp_round.sv
// ----------------------------------------------------------------------------
// gfmp_round: one exponent round of the pipeline
// Optionally squares the accumulator, then multiplies it by a or by one,
// one multiplier slice per register stage.
// ----------------------------------------------------------------------------
module gfmp_round #(
  parameter int unsigned EXPONENT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  gfmp_pkg::gfmp_word_t     in_i,
  input  logic [EXPONENT_BITS-1:0] e_i,
  output gfmp_pkg::gfmp_word_t     out_o,
  output logic [EXPONENT_BITS-1:0] e_o
);

  localparam int unsigned W    = gfmp_pkg::GfW;
  localparam int unsigned CW   = gfmp_pkg::ChunkW;
  localparam int unsigned NSUB = gfmp_pkg::NumSlices;

  // Stage registers.
  logic                     v_q    [NSUB];
  logic                     kind_q [NSUB];
  logic [W-1:0]             a_q    [NSUB];
  logic [W-1:0]             t_q    [NSUB];
  logic [EXPONENT_BITS-1:0] e_q    [NSUB];
  logic [W-1:0]             acc2_q [NSUB-1];
  logic [W-1:0]             m_q    [NSUB-1];

  // Stage inputs and next partial products.
  logic                     vin_s    [NSUB];
  logic                     kind_s   [NSUB];
  logic [W-1:0]             a_s      [NSUB];
  logic [EXPONENT_BITS-1:0] e_s      [NSUB];
  logic [W-1:0]             x_s      [NSUB];
  logic [W-1:0]             m_s      [NSUB];
  logic [W-1:0]             tin_s    [NSUB];
  logic [W-1:0]             t_d      [NSUB];

  // Round entry: square for a power, and pick the factor a or one.
  logic         use_a;
  logic [W-1:0] acc2_in;

  always_comb begin
    use_a   = (in_i.kind == gfmp_pkg::KindPow) ? e_i[EXPONENT_BITS-1] : in_i.pend;
    acc2_in = (in_i.kind == gfmp_pkg::KindPow) ? gfmp_pkg::gf_sqr(in_i.acc) : in_i.acc;
  end

  // Route each stage's inputs: the first from the round entry, the rest
  // from the stage before.
  for (genvar j = 0; j < NSUB; j++) begin : g_stage
    if (j == 0) begin : g_first
      always_comb begin
        vin_s[j]  = in_i.valid;
        kind_s[j] = in_i.kind;
        a_s[j]    = in_i.a;
        e_s[j]    = e_i;
        x_s[j]    = acc2_in;
        m_s[j]    = use_a ? in_i.a : gfmp_pkg::GfOne;
        tin_s[j]  = '0;
      end
    end else begin : g_next
      always_comb begin
        vin_s[j]  = v_q[j-1];
        kind_s[j] = kind_q[j-1];
        a_s[j]    = a_q[j-1];
        e_s[j]    = e_q[j-1];
        x_s[j]    = acc2_q[j-1];
        m_s[j]    = m_q[j-1];
        tin_s[j]  = t_q[j-1];
      end
    end
    assign t_d[j] = gfmp_pkg::gf_step(tin_s[j], x_s[j], m_s[j][(NSUB-1-j)*CW +: CW]);
  end

  // Valid bits travel with the data and are the only reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NSUB; j++) begin
        v_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      for (int j = 0; j < NSUB; j++) begin
        v_q[j] <= vin_s[j];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NSUB; j++) begin
        kind_q[j] <= kind_s[j];
        a_q[j]    <= a_s[j];
        e_q[j]    <= e_s[j];
        t_q[j]    <= t_d[j];
      end
      for (int j = 0; j < NSUB-1; j++) begin
        acc2_q[j] <= x_s[j];
        m_q[j]    <= m_s[j];
      end
    end
  end

  // Hand the finished accumulator to the next round.
  always_comb begin
    out_o.valid = v_q[NSUB-1];
    out_o.kind  = kind_q[NSUB-1];
    out_o.pend  = 1'b0;
    out_o.a     = a_q[NSUB-1];
    out_o.acc   = t_q[NSUB-1];
    e_o         = e_q[NSUB-1] << 1;
  end

endmodule

FILE: sv/gf128_multiply_and_power_core.sv
// ----------------------------------------------------------------------------
// gf128_multiply_and_power_core: GF(2^128) multiply and power, XTS layout
// Computes a*b or a^e modulo x^128 + x^7 + x^2 + x + 1 in a pipeline of
// one round per exponent bit.
// ----------------------------------------------------------------------------
//
// Channel  Handshake               Word
// -------  ----------------------  ----------------------------------------
// in       in_valid_i / in_ready_o  kind_i, a_low/high_i, b_low/high_i, power_i
// out      out_valid_o / out_ready_i product_low_o, product_high_o
//
// A new word may enter every cycle while in_ready_o is high. Each exponent
// round runs its multiply as four 32-bit slice stages, and an output
// register follows the last round. A multiply passes through the same
// rounds, multiplying by one after the first. Reset clears only valid bits.
// The pipeline moves whenever its last stage is empty or the output register
// can take a word, so input is still taken while a result waits.
// ----------------------------------------------------------------------------
module gf128_multiply_and_power_core #(
  parameter int unsigned EXPONENT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [63:0] a_low_i,
  input  logic [63:0] a_high_i,
  input  logic [63:0] b_low_i,
  input  logic [63:0] b_high_i,
  input  logic [31:0] power_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] product_low_o,
  output logic [63:0] product_high_o
);

  localparam int unsigned W = gfmp_pkg::GfW;

  gfmp_pkg::gfmp_word_t     word_s [EXPONENT_BITS+1];
  logic [EXPONENT_BITS-1:0] e_s    [EXPONENT_BITS+1];
  logic                     en;
  logic                     out_valid_q;
  logic [W-1:0]             product_q;

  // Entry word: a power starts from one, a multiply from b.
  always_comb begin
    word_s[0].valid = in_valid_i;
    word_s[0].kind  = kind_i;
    word_s[0].pend  = (kind_i == gfmp_pkg::KindMul);
    word_s[0].a     = {a_high_i, a_low_i};
    word_s[0].acc   = (kind_i == gfmp_pkg::KindPow) ? gfmp_pkg::GfOne : {b_high_i, b_low_i};
    e_s[0]          = EXPONENT_BITS'(power_i);
  end

  // Global advance: safe unless the last stage holds a word with nowhere to go.
  assign en         = out_ready_i | ~out_valid_q | ~word_s[EXPONENT_BITS].valid;
  assign in_ready_o = en;

  // One round per exponent bit, most significant first.
  for (genvar r = 0; r < EXPONENT_BITS; r++) begin : g_round
    gfmp_round #(
      .EXPONENT_BITS(EXPONENT_BITS)
    ) u_round (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .in_i  (word_s[r]),
      .e_i   (e_s[r]),
      .out_o (word_s[r+1]),
      .e_o   (e_s[r+1])
    );
  end

  // Output register: valid control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && word_s[EXPONENT_BITS].valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: result data.
  always_ff @(posedge clk_i) begin
    if (en && word_s[EXPONENT_BITS].valid) begin
      product_q <= word_s[EXPONENT_BITS].acc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign product_low_o  = product_q[63:0];
  assign product_high_o = product_q[W-1:64];

endmodule

FILE: sv/gfmp_checker.sv
// ----------------------------------------------------------------------------
// gfmp_checker: port-level checks for the GF(2^128) core
// Watches the handshakes and result word of the top level over time.
// ----------------------------------------------------------------------------
module gfmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] product_low_o,
  input logic [63:0] product_high_o
);

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(product_low_o) && $stable(product_high_o)))
    else $error("result word changed while stalled");

  // The input side only stalls while a result waits unaccepted.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a waiting result");

  // A waiting result with a ready sink never blocks new words.
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> in_ready_o)
    else $error("input stalled while the result is taken");

  // No result appears at the first edge after reset is released.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind gf128_multiply_and_power_core gfmp_checker u_checker (.*);
